>>> sv/rmst_pkg.sv
`timescale 1ns / 1ps

package rmst_pkg;

	localparam int DATA_W  = 32;
	localparam int POS_W   = 10;
	localparam int COUNT_W = 11;

	localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

	// Values are kept with the sign bit inverted so that an unsigned
	// compare orders them as signed numbers.
	localparam logic [DATA_W-1:0] SIGN_FLIP  = 32'h8000_0000;
	localparam logic [DATA_W-1:0] BIASED_MIN = 32'h0000_0000;

	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_W_READ,
		ST_W_UPD,
		ST_Q_LEFT,
		ST_Q_LACC,
		ST_Q_RIGHT,
		ST_Q_RACC,
		ST_Q_DONE
	} state_t;

endpackage

>>> sv/rmst_node_ram.sv
`timescale 1ns / 1ps

module rmst_node_ram #(
	parameter int ADDR_W = 11,
	parameter int DATA_W = 32
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**ADDR_W];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> sv/range_max_segment_tree_top.sv
`timescale 1ns / 1ps

// Range-maximum segment tree over LEAVES signed 32-bit positions.
// Input channel (in_valid / in_stall): mode 0 writes value at position and
// refreshes every ancestor; mode 1 asks for the maximum over the inclusive
// range [range_low, range_high]. A transfer happens when in_valid is high
// and in_stall is low. Writes give no result; each query gives one result
// on the output channel (out_valid / out_stall): max_value and range_empty.
// range_empty flags low above high or high at or beyond element_count.
// Structure: all tree nodes live in one memory with a write port and a
// registered read port, and one comparator serves every step. A write reads
// the sibling and then writes the parent at each tree level up to the root.
// A query walks both bounds up a level at a time, reading and folding in a
// node on each side where needed; a flagged query skips the walk. One item
// is in work at a time; in_stall is high throughout.
// Reset: after arst_n rises, a clearing pass writes the most negative value
// to all 2*LEAVES nodes, one a cycle, with in_stall high for that time.
// element_count resets to 1024 and may be written via cfg_write_en at any
// idle moment. A finished result waits in the output register while the
// receiver stalls; writes are taken meanwhile, a further query holds at its end.

module range_max_segment_tree_top #(
	parameter int LEAVES = 1024
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write_en,
	input  logic [rmst_pkg::COUNT_W-1:0]       cfg_write_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               mode,
	input  logic [rmst_pkg::POS_W-1:0]         position,
	input  logic signed [rmst_pkg::DATA_W-1:0] value,
	input  logic [rmst_pkg::POS_W-1:0]         range_low,
	input  logic [rmst_pkg::POS_W-1:0]         range_high,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [rmst_pkg::DATA_W-1:0] max_value,
	output logic                               range_empty
);

	import rmst_pkg::*;

	localparam int AW = $clog2(2 * LEAVES);
	localparam int NW = AW + 1;
	localparam logic [AW-1:0] LAST_NODE = AW'(2 * LEAVES - 1);
	localparam logic [AW-1:0] ROOT_NODE = AW'(1);
	localparam logic [31:0]   LEAVES_W  = 32'(LEAVES);

	state_t state_q, state_d;

	logic [AW-1:0]      clr_q;
	logic [COUNT_W-1:0] element_count_q;
	logic [AW-1:0]      k_q;
	logic [NW-1:0]      l_q, r_q;
	logic [DATA_W-1:0]  acc_q;
	logic               empty_q;
	logic               out_valid_q;
	logic [DATA_W-1:0]  max_value_q;
	logic               range_empty_q;

	logic              ram_we, ram_re;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	logic [DATA_W-1:0] ram_wdata, ram_rdata;

	logic              pos_ok, q_empty, out_free;
	logic [AW-1:0]     leaf_k;
	logic [NW-1:0]     l_init, r_init, r_dec;
	logic [DATA_W-1:0] max_out;

	// Decode of the item at the input
	assign pos_ok  = 32'(position) < LEAVES_W;
	assign leaf_k  = AW'(LEAVES_W + 32'(position));
	assign q_empty = (range_low > range_high) ||
	                 ({1'b0, range_high} >= element_count_q) ||
	                 (32'(range_high) >= LEAVES_W);
	assign l_init  = NW'(LEAVES_W + 32'(range_low));
	assign r_init  = NW'(LEAVES_W + 32'(range_high) + 32'd1);
	assign r_dec   = r_q - NW'(1);

	// The one shared comparator: running value against memory read data
	assign max_out = (ram_rdata > acc_q) ? ram_rdata : acc_q;

	assign out_free = !out_valid_q || !out_stall;

	rmst_node_ram #(
		.ADDR_W (AW),
		.DATA_W (DATA_W)
	) u_node_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = max_out;
		ram_re    = 1'b0;
		ram_raddr = '0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = BIASED_MIN;
				if (clr_q == LAST_NODE) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					if (mode == MODE_WRITE) begin
						// store the leaf now, then climb; drop writes beyond the tree
						if (pos_ok) begin
							ram_we    = 1'b1;
							ram_waddr = leaf_k;
							ram_wdata = value ^ SIGN_FLIP;
							state_d   = ST_W_READ;
						end
					end else begin
						state_d = q_empty ? ST_Q_DONE : ST_Q_LEFT;
					end
				end
			end
			ST_W_READ: begin
				if (k_q == ROOT_NODE) begin
					state_d = ST_IDLE;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = k_q ^ AW'(1);
					state_d   = ST_W_UPD;
				end
			end
			ST_W_UPD: begin
				ram_we    = 1'b1;
				ram_waddr = k_q >> 1;
				ram_wdata = max_out;
				state_d   = ST_W_READ;
			end
			ST_Q_LEFT: begin
				if (!(l_q < r_q)) begin
					state_d = ST_Q_DONE;
				end else if (l_q[0]) begin
					ram_re    = 1'b1;
					ram_raddr = l_q[AW-1:0];
					state_d   = ST_Q_LACC;
				end else begin
					state_d = ST_Q_RIGHT;
				end
			end
			ST_Q_LACC: begin
				state_d = ST_Q_RIGHT;
			end
			ST_Q_RIGHT: begin
				if (r_q[0]) begin
					ram_re    = 1'b1;
					ram_raddr = r_dec[AW-1:0];
					state_d   = ST_Q_RACC;
				end else begin
					state_d = ST_Q_LEFT;
				end
			end
			ST_Q_RACC: begin
				state_d = ST_Q_LEFT;
			end
			ST_Q_DONE: begin
				// hold here until the output register is free
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Clearing pass address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (state_q == ST_CLEAR) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			element_count_q <= COUNT_RESET;
		end else if (cfg_write_en) begin
			element_count_q <= cfg_write_data;
		end
	end

	// Walk registers: tree index for writes, the two bounds and the running
	// maximum for queries
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					acc_q   <= (mode == MODE_WRITE) ? (value ^ SIGN_FLIP) : BIASED_MIN;
					k_q     <= leaf_k;
					l_q     <= l_init;
					r_q     <= r_init;
					empty_q <= q_empty;
				end
			end
			ST_W_UPD: begin
				acc_q <= max_out;
				k_q   <= k_q >> 1;
			end
			ST_Q_LEFT: begin
				if ((l_q < r_q) && l_q[0]) begin
					l_q <= l_q + NW'(1);
				end
			end
			ST_Q_LACC: begin
				acc_q <= max_out;
			end
			ST_Q_RIGHT: begin
				if (r_q[0]) begin
					r_q <= r_dec;
				end else begin
					l_q <= l_q >> 1;
					r_q <= r_q >> 1;
				end
			end
			ST_Q_RACC: begin
				acc_q <= max_out;
				l_q   <= l_q >> 1;
				r_q   <= r_q >> 1;
			end
			default: begin
			end
		endcase
	end

	// Output register: load at the end of a query, clear on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_Q_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_Q_DONE && out_free) begin
			max_value_q   <= acc_q ^ SIGN_FLIP;
			range_empty_q <= empty_q;
		end
	end

	assign in_stall    = (state_q != ST_IDLE);
	assign out_valid   = out_valid_q;
	assign max_value   = max_value_q;
	assign range_empty = range_empty_q;

endmodule

>>> sv/rmst_checker.sv
`timescale 1ns / 1ps

module rmst_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_stall,
	input logic                               mode,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic signed [rmst_pkg::DATA_W-1:0] max_value,
	input logic                               range_empty
);

	import rmst_pkg::*;

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(max_value) && $stable(range_empty))
		else $error("result changed while stalled");

	// A query transfer keeps the input busy in the next cycle
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && mode == MODE_QUERY |=> in_stall)
		else $error("input free straight after a query transfer");

	// A result only appears at the end of work
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared while idle");

	// A flagged range reports the most negative value
	a_empty_min: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && range_empty |-> max_value == SIGN_FLIP)
		else $error("flagged range with a value other than the minimum");

endmodule

bind range_max_segment_tree_top rmst_checker u_rmst_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.mode        (mode),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.max_value   (max_value),
	.range_empty (range_empty)
);
